FILE: design/skts_pkg.sv
// Shared types and codes of the sorted key table search and insert core.
package skts_pkg;

    localparam int OUTCOME_W = 3;
    localparam int POS_W     = 11;
    localparam int SIDE_W    = 2;
    localparam int COUNT_W   = 11;

    localparam logic [OUTCOME_W-1:0] OUT_FOUND    = 3'd0;
    localparam logic [OUTCOME_W-1:0] OUT_ABSENT   = 3'd1;
    localparam logic [OUTCOME_W-1:0] OUT_INSERTED = 3'd2;
    localparam logic [OUTCOME_W-1:0] OUT_FULL     = 3'd3;
    localparam logic [OUTCOME_W-1:0] OUT_IGNORED  = 3'd4;

    localparam logic [SIDE_W-1:0] SIDE_WITHIN = 2'd0;
    localparam logic [SIDE_W-1:0] SIDE_BELOW  = 2'd1;
    localparam logic [SIDE_W-1:0] SIDE_ABOVE  = 2'd2;

    typedef struct packed {
        logic [OUTCOME_W-1:0] outcome;
        logic [POS_W-1:0]     position;
        logic [SIDE_W-1:0]    range_side;
        logic [COUNT_W-1:0]   entries_now;
    } skts_result_t;

endpackage

FILE: design/sorted_key_table_search_insert_core.sv
// Top level of the sorted key table: stream ports, key store, sequencer and result register.
//
// The block keeps an ascending table of unique keys in a single-port-read,
// single-port-write memory together with a count of the keys held.
// Each request on the s_axis channel carries a key in tdata and, in tuser,
// the command (lookup or attach) and a flag saying whether a key is present.
// Every request yields exactly one result on the m_axis channel: the outcome
// code in tuser, and position, range side and entry count in tdata.
// Requests are handled one at a time, the next being taken once the previous
// result has moved into the output register. A request without a key goes
// straight to its result. A keyed request on a non-empty table checks the key
// against the first and last entries, then bisects, each step waiting for one
// registered memory read. An insert then moves each later entry up by one
// place at one entry per cycle, then writes the new key. A result waits in
// the output register while the receiver stalls; the next request is still
// accepted and worked on, and only its own result waits for that register
// to be free.
// Reset empties the table by clearing the count; the memory itself is not
// cleared and needs no clearing pass.
module sorted_key_table_search_insert_core import skts_pkg::*; #(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_BITS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // [63:0] search_key
    input  logic [1:0]  s_axis_tuser,  // [0] cmd, [1] has_key
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // [10:0] position, [12:11] range_side, [23:13] entries_now
    output logic [2:0]  m_axis_tuser   // [2:0] outcome
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [KEY_BITS-1:0] wr_data;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [KEY_BITS-1:0] rd_data;

    logic         res_valid;
    logic         res_ready;
    skts_result_t res;

    logic         m_valid_reg;
    skts_result_t m_res_reg;

    // Only the low KEY_BITS bits of the key take part; higher bits are ignored.
    skts_ctrl #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .KEY_BITS(KEY_BITS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_cmd    (s_axis_tuser[0]),
        .in_has_key(s_axis_tuser[1]),
        .in_key    (s_axis_tdata[KEY_BITS-1:0]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    // The sequencer never reads the entry it writes in the same cycle.
    skts_key_ram #(
        .DEPTH(TABLE_DEPTH),
        .DATA_W(KEY_BITS)
    ) u_key_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // The result register is free when empty or when its contents leave this cycle.
    assign res_ready = !m_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_res_reg.outcome;
    assign m_axis_tdata  = {m_res_reg.entries_now, m_res_reg.range_side, m_res_reg.position};

endmodule

FILE: design/skts_key_ram.sv
// Key store: one write port, one read port, registered read data.
module skts_key_ram #(
    parameter int DEPTH = 1024,
    parameter int DATA_W = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: design/skts_ctrl.sv
// Sequencer: range checks, bisection over the key store and the shifting insert.
module skts_ctrl import skts_pkg::*; #(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_BITS = 64,
    localparam int ADDR_W = $clog2(TABLE_DEPTH),
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_cmd,
    input  logic                in_has_key,
    input  logic [KEY_BITS-1:0] in_key,
    output logic                res_valid,
    input  logic                res_ready,
    output skts_result_t        res,
    output logic                wr_en,
    output logic [ADDR_W-1:0]   wr_addr,
    output logic [KEY_BITS-1:0] wr_data,
    output logic                rd_en,
    output logic [ADDR_W-1:0]   rd_addr,
    input  logic [KEY_BITS-1:0] rd_data
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_CHK_FIRST = 4'd1;
    localparam logic [3:0] ST_CHK_LAST  = 4'd2;
    localparam logic [3:0] ST_BIS_ISSUE = 4'd3;
    localparam logic [3:0] ST_BIS_CMP   = 4'd4;
    localparam logic [3:0] ST_DECIDE    = 4'd5;
    localparam logic [3:0] ST_SHIFT     = 4'd6;
    localparam logic [3:0] ST_INS       = 4'd7;
    localparam logic [3:0] ST_DONE      = 4'd8;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

    logic [3:0]           state_reg, state_next;
    logic                 cmd_reg, cmd_next;
    logic [KEY_BITS-1:0]  key_reg, key_next;
    logic [CNT_W-1:0]     lo_reg, lo_next;
    logic [CNT_W-1:0]     hi_reg, hi_next;
    logic [CNT_W-1:0]     mid_reg, mid_next;
    logic [CNT_W-1:0]     pos_reg, pos_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [SIDE_W-1:0]    side_reg, side_next;
    logic                 found_reg, found_next;
    logic [OUTCOME_W-1:0] outcome_reg, outcome_next;

    logic [CNT_W-1:0] mid_calc;
    logic [CNT_W-1:0] count_m1;
    logic [CNT_W-1:0] idx_m1;
    logic [CNT_W-1:0] idx_m2;

    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign count_m1 = count_reg - CNT_W'(1);
    assign idx_m1   = idx_reg - CNT_W'(1);
    assign idx_m2   = idx_reg - CNT_W'(2);

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    assign res.outcome     = outcome_reg;
    assign res.position    = POS_W'(pos_reg);
    assign res.range_side  = side_reg;
    assign res.entries_now = COUNT_W'(count_reg);

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        key_next     = key_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        pos_next     = pos_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        side_next    = side_reg;
        found_next   = found_reg;
        outcome_next = outcome_reg;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = key_reg;
        rd_en        = 1'b0;
        rd_addr      = '0;

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd_next   = in_cmd;
                    key_next   = in_key;
                    pos_next   = '0;
                    side_next  = SIDE_WITHIN;
                    found_next = 1'b0;
                    if (!in_has_key) begin
                        outcome_next = OUT_IGNORED;
                        state_next   = ST_DONE;
                    end else if (count_reg == '0) begin
                        // An empty table puts every key below all entries.
                        side_next  = SIDE_BELOW;
                        state_next = ST_DECIDE;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        state_next = ST_CHK_FIRST;
                    end
                end
            end
            ST_CHK_FIRST: begin
                if (key_reg < rd_data) begin
                    side_next  = SIDE_BELOW;
                    state_next = ST_DECIDE;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = count_m1[ADDR_W-1:0];
                    state_next = ST_CHK_LAST;
                end
            end
            ST_CHK_LAST: begin
                if (key_reg > rd_data) begin
                    side_next  = SIDE_ABOVE;
                    pos_next   = count_reg;
                    state_next = ST_DECIDE;
                end else begin
                    lo_next    = '0;
                    hi_next    = count_reg;
                    state_next = ST_BIS_ISSUE;
                end
            end
            ST_BIS_ISSUE: begin
                if (lo_reg < hi_reg) begin
                    rd_en      = 1'b1;
                    rd_addr    = mid_calc[ADDR_W-1:0];
                    mid_next   = mid_calc;
                    state_next = ST_BIS_CMP;
                end else begin
                    pos_next   = lo_reg;
                    state_next = ST_DECIDE;
                end
            end
            ST_BIS_CMP: begin
                if (rd_data == key_reg) begin
                    found_next = 1'b1;
                    pos_next   = mid_reg;
                    state_next = ST_DECIDE;
                end else begin
                    if (rd_data < key_reg) begin
                        lo_next = mid_reg + CNT_W'(1);
                    end else begin
                        hi_next = mid_reg;
                    end
                    state_next = ST_BIS_ISSUE;
                end
            end
            ST_DECIDE: begin
                if (found_reg) begin
                    outcome_next = OUT_FOUND;
                    state_next   = ST_DONE;
                end else if (!cmd_reg) begin
                    outcome_next = OUT_ABSENT;
                    state_next   = ST_DONE;
                end else if (count_reg == FULL_COUNT) begin
                    outcome_next = OUT_FULL;
                    state_next   = ST_DONE;
                end else if (count_reg > pos_reg) begin
                    rd_en      = 1'b1;
                    rd_addr    = count_m1[ADDR_W-1:0];
                    idx_next   = count_reg;
                    state_next = ST_SHIFT;
                end else begin
                    state_next = ST_INS;
                end
            end
            ST_SHIFT: begin
                // Entry idx-1 is on the read port; it moves up to idx.
                wr_en    = 1'b1;
                wr_addr  = idx_reg[ADDR_W-1:0];
                wr_data  = rd_data;
                idx_next = idx_m1;
                if (idx_m1 > pos_reg) begin
                    rd_en   = 1'b1;
                    rd_addr = idx_m2[ADDR_W-1:0];
                end else begin
                    state_next = ST_INS;
                end
            end
            ST_INS: begin
                wr_en        = 1'b1;
                wr_addr      = pos_reg[ADDR_W-1:0];
                wr_data      = key_reg;
                count_next   = count_reg + CNT_W'(1);
                outcome_next = OUT_INSERTED;
                state_next   = ST_DONE;
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        key_reg     <= key_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        pos_reg     <= pos_next;
        idx_reg     <= idx_next;
        side_reg    <= side_next;
        found_reg   <= found_next;
        outcome_reg <= outcome_next;
    end

endmodule

FILE: bench/tb.sv
// Self-checking testbench for the sorted key table search and insert core.
`timescale 1ns / 100ps

module tb;
    import skts_pkg::*;

    localparam int TABLE_DEPTH     = 1024;
    localparam int RANDOM_REQUESTS = 240;
    // The slowest legal request is an insert at the bottom of an almost full
    // table, plus a long receiver stall and a long sender gap. The limit
    // leaves several times their sum as margin.
    localparam int STALL_LIMIT     = 8000;
    localparam int SETTLE_CYCLES   = 50;

    localparam logic [63:0] MID_KEY = 64'h8000_0000_0000_0000;

    // One request as the sender sees it; packed into tdata and tuser below.
    typedef struct packed {
        logic        cmd;
        logic        has_key;
        logic [63:0] search_key;
    } key_request_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;   // [63:0] search_key
    logic [1:0]  s_axis_tuser = '0;   // [0] cmd, [1] has_key
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // [10:0] position, [12:11] range_side, [23:13] entries_now
    logic [2:0]  m_axis_tuser;        // [2:0] outcome

    sorted_key_table_search_insert_core #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .KEY_BITS(64)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Requests waiting to be driven, and the results the table should give
    // for requests already taken by the block, oldest first.
    key_request_t pending_requests[$];
    skts_result_t expected_results[$];
    // Every keyed request's key so far; random requests draw on it so that many of
    // them hit keys that are already held, or their close neighbours.
    logic [63:0]  key_pool[$];

    // Our own copy of the ascending key table and its fill level.
    logic [63:0]  held_keys[TABLE_DEPTH];
    int unsigned  held_count = 0;

    key_request_t in_flight_req = '0;
    logic         req_taken = 1'b0;
    int unsigned  requests_queued = 0;
    int unsigned  requests_accepted = 0;
    int unsigned  mismatches = 0;
    int unsigned  idle_cycles = 0;
    int unsigned  send_gap = 0;
    int unsigned  send_calm = 0;
    int unsigned  recv_stall = 0;
    int unsigned  recv_calm = 0;

    // Works out the result of one request and updates the table copy the
    // way an attach of an absent key would.
    function automatic skts_result_t search_and_insert(input key_request_t rq);
        skts_result_t res;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        int unsigned  pos;
        int unsigned  i;
        logic         found;
        res.outcome     = OUT_IGNORED;
        res.position    = '0;
        res.range_side  = SIDE_WITHIN;
        res.entries_now = COUNT_W'(held_count);
        if (!rq.has_key) begin
            return res;
        end
        found = 1'b0;
        pos   = 0;
        if (held_count == 0 || rq.search_key < held_keys[0]) begin
            // An empty table counts every key as lying below all entries.
            res.range_side = SIDE_BELOW;
        end else if (rq.search_key > held_keys[held_count-1]) begin
            res.range_side = SIDE_ABOVE;
            pos = held_count;
        end else begin
            lo = 0;
            hi = held_count;
            while (lo < hi && !found) begin
                mid = lo + (hi - lo) / 2;
                if (held_keys[mid] == rq.search_key) begin
                    found = 1'b1;
                    pos = mid;
                end else if (held_keys[mid] < rq.search_key) begin
                    lo = mid + 1;
                end else begin
                    hi = mid;
                end
            end
            if (!found) begin
                pos = lo;
            end
        end
        res.position = POS_W'(pos);
        if (found) begin
            // Attaching a key that is already held changes nothing.
            res.outcome = OUT_FOUND;
        end else if (!rq.cmd) begin
            res.outcome = OUT_ABSENT;
        end else if (held_count >= TABLE_DEPTH) begin
            res.outcome = OUT_FULL;
        end else begin
            for (i = held_count; i > pos; i--) begin
                held_keys[i] = held_keys[i-1];
            end
            held_keys[pos] = rq.search_key;
            held_count++;
            res.outcome     = OUT_INSERTED;
            res.entries_now = COUNT_W'(held_count);
        end
        return res;
    endfunction

    // Mostly short pauses, now and then a long one.
    function automatic int unsigned pick_pause();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end
        if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic queue_request(input logic cmd, input logic has_key, input logic [63:0] key);
        key_request_t rq;
        rq.cmd        = cmd;
        rq.has_key    = has_key;
        rq.search_key = key;
        pending_requests.push_back(rq);
        requests_queued++;
        if (has_key) begin
            key_pool.push_back(key);
        end
    endtask

    task automatic queue_random_request();
        logic        cmd;
        logic        has_key;
        logic [63:0] key;
        int unsigned pick;
        cmd     = ($urandom_range(0, 99) < 60);
        has_key = ($urandom_range(0, 99) < 92);
        pick    = $urandom_range(0, 99);
        if (pick < 35) begin
            key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        end else if (pick < 50) begin
            key = key_pool[$urandom_range(0, key_pool.size() - 1)];
            key = $urandom_range(0, 1) ? key + 64'd1 : key - 64'd1;
        end else if (pick < 58) begin
            case ($urandom_range(0, 3))
                0: key = '0;
                1: key = 64'd1;
                2: key = {{63{1'b1}}, 1'b0};
                default: key = '1;
            endcase
        end else begin
            key = {$urandom, $urandom};
        end
        // Random requests never store the smallest and largest keys, so that lookups
        // below and above every entry stay possible.
        if (cmd && (key == '0 || key == '1)) begin
            cmd = 1'b0;
        end
        queue_request(cmd, has_key, key);
    endtask

    // Returns once every queued request has been taken and answered, just
    // after a rising edge so that nothing races with the driver.
    task automatic wait_until_drained();
        do begin
            @(negedge aclk);
        end while (requests_accepted != requests_queued || expected_results.size() != 0);
        @(posedge aclk);
    endtask

    // Driver: presents one request at a time on the falling edge and keeps
    // it stable until the block takes it.
    always @(negedge aclk) begin : request_driver
        key_request_t next_req;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || req_taken) begin
            if (send_gap != 0) begin
                send_gap      <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
                next_req      = pending_requests.pop_front();
                in_flight_req <= next_req;
                s_axis_tdata  <= next_req.search_key;
                s_axis_tuser  <= {next_req.has_key, next_req.cmd};
                s_axis_tvalid <= 1'b1;
                // Now and then a long run of back-to-back requests.
                if (send_calm != 0) begin
                    send_calm <= send_calm - 1;
                    send_gap  <= 0;
                end else begin
                    send_gap <= pick_pause();
                    if ($urandom_range(0, 24) == 0) begin
                        send_calm <= $urandom_range(20, 60);
                    end
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // The receiver stalls at random, with stretches of steady readiness.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (recv_stall != 0) begin
            recv_stall    <= recv_stall - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (recv_calm != 0) begin
                recv_calm <= recv_calm - 1;
            end else begin
                recv_stall <= pick_pause();
                if ($urandom_range(0, 29) == 0) begin
                    recv_calm <= $urandom_range(20, 60);
                end
            end
        end
    end

    // Monitor: on each rising edge, checks a delivered result against the
    // oldest prediction, predicts the result of a request just taken, and
    // keeps the watchdog that ends a run which has stopped moving.
    always @(posedge aclk) begin : result_monitor
        skts_result_t got;
        skts_result_t want;
        logic         request_seen;
        logic         result_seen;
        if (aresetn) begin
            request_seen = s_axis_tvalid && s_axis_tready;
            result_seen  = m_axis_tvalid && m_axis_tready;
            req_taken <= request_seen;
            if (result_seen) begin
                got.outcome     = m_axis_tuser;
                got.position    = m_axis_tdata[POS_W-1:0];
                got.range_side  = m_axis_tdata[POS_W +: SIDE_W];
                got.entries_now = m_axis_tdata[POS_W+SIDE_W +: COUNT_W];
                if (expected_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with none expected: outcome %0d position %0d",
                             $time, got.outcome, got.position);
                end else begin
                    want = expected_results.pop_front();
                    if (got.outcome !== want.outcome) begin
                        mismatches++;
                        $display("%0t: outcome expected %0d, got %0d",
                                 $time, want.outcome, got.outcome);
                    end
                    if (got.position !== want.position) begin
                        mismatches++;
                        $display("%0t: position expected %0d, got %0d",
                                 $time, want.position, got.position);
                    end
                    if (got.range_side !== want.range_side) begin
                        mismatches++;
                        $display("%0t: range side expected %0d, got %0d",
                                 $time, want.range_side, got.range_side);
                    end
                    if (got.entries_now !== want.entries_now) begin
                        mismatches++;
                        $display("%0t: entry count expected %0d, got %0d",
                                 $time, want.entries_now, got.entries_now);
                    end
                end
            end
            if (request_seen) begin
                expected_results.push_back(search_and_insert(in_flight_req));
                requests_accepted <= requests_accepted + 1;
            end
            if (request_seen || result_seen) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no request or result moved for %0d cycles", $time, idle_cycles);
                $display("tb NOT OK");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Stimulus: a directed opening on the empty table, a random middle and
    // a last set of requests against the table that the middle has built.
    initial begin
        // Opening requests against an empty table: ignored requests, lookups
        // of the extreme keys, then inserts below, above and between entries.
        queue_request(1'b0, 1'b0, {$urandom, $urandom});
        queue_request(1'b1, 1'b0, {$urandom, $urandom});
        queue_request(1'b0, 1'b1, '0);
        queue_request(1'b0, 1'b1, '1);
        queue_request(1'b1, 1'b1, MID_KEY);
        queue_request(1'b0, 1'b1, MID_KEY);
        queue_request(1'b1, 1'b1, MID_KEY);
        queue_request(1'b0, 1'b1, '0);
        queue_request(1'b0, 1'b1, '1);
        queue_request(1'b1, 1'b1, 64'd1);
        queue_request(1'b1, 1'b1, {{63{1'b1}}, 1'b0});
        queue_request(1'b1, 1'b1, MID_KEY - 64'd1);
        queue_request(1'b1, 1'b1, MID_KEY + 64'd1);
        queue_request(1'b0, 1'b1, MID_KEY + 64'd2);
        queue_request(1'b0, 1'b1, 64'd1);
        queue_request(1'b0, 1'b1, {{63{1'b1}}, 1'b0});
        queue_request(1'b1, 1'b0, '1);
        queue_request(1'b0, 1'b1, MID_KEY - 64'd2);
        queue_request(1'b1, 1'b1, MID_KEY + 64'd2);
        queue_request(1'b0, 1'b1, 64'h0180_0000_0000_0000);

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            queue_random_request();
        end

        // Reset is held low at first and released on a falling edge.
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        wait_until_drained();

        // Last set: lookups and attaches beyond both ends, attaches of held keys, a
        // held-key lookup, new attaches, an ignored request, then random requests.
        queue_request(1'b0, 1'b1, '0);
        queue_request(1'b0, 1'b1, '1);
        queue_request(1'b1, 1'b1, '0);
        queue_request(1'b1, 1'b1, '1);
        queue_request(1'b1, 1'b1, held_keys[0]);
        queue_request(1'b1, 1'b1, held_keys[held_count-1]);
        queue_request(1'b0, 1'b1, held_keys[held_count/2]);
        queue_request(1'b1, 1'b1, held_keys[held_count/2] + 64'd1);
        queue_request(1'b1, 1'b1, {$urandom, $urandom});
        queue_request(1'b1, 1'b0, held_keys[3]);
        for (int n = 0; n < 20; n++) begin
            queue_random_request();
        end

        wait_until_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (mismatches == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
